// ===== rtl/stt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg
// Shared constants, token kinds and scan modes for the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned PositionBits = 32;
  localparam int unsigned LengthBits   = 16;
  localparam int unsigned KindBits     = 6;
  localparam int unsigned WordDepth    = 6;

  typedef enum logic [KindBits-1:0] {
    K_PLUS = 6'd0, K_MINUS, K_ARROW, K_STAR, K_SLASH, K_DSLASH, K_PERCENT,
    K_COMMA, K_COLON, K_ASSIGN, K_SEMI, K_DOT, K_ELLIPSIS, K_PL, K_PR,
    K_SL, K_SR, K_CL, K_CR, K_COMMENT, K_BANG, K_BANG_EQ, K_EQUAL, K_GT,
    K_GE, K_LT, K_LE, K_AND, K_OR, K_PIPE, K_STRING, K_INT, K_FLOAT,
    K_IDENT, K_EOF, K_INVALID,
    K_KW_ANY, K_KW_TYPE, K_KW_IF, K_KW_ELSE, K_KW_TRUE, K_KW_FALSE, K_KW_FN,
    K_KW_RETURN, K_KW_WHILE, K_KW_FOR, K_KW_INT, K_KW_FLOAT, K_KW_BOOL,
    K_KW_STRING
  } kind_e;

  typedef enum logic [3:0] {
    M_IDLE, M_PAIR, M_DOT, M_DOTDOT, M_IDENT, M_INT, M_INTDOT, M_FLOAT,
    M_STRING, M_COMMENT
  } mode_e;

  typedef logic [WordDepth-1:0][7:0] word_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_ident_char(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
           (c == 8'h5f);
  endfunction

  function automatic logic kw_eq(word_t w, logic [2:0] n, logic [47:0] s,
                                 logic [2:0] sn);
    logic ok;
    ok = (n == sn);
    for (int i = 0; i < 6; i++) begin
      if (i < int'(sn) && w[i] != s[47-8*i -: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic kind_e ident_kind(word_t w, logic [2:0] n);
    kind_e k;
    k = K_IDENT;
    if (kw_eq(w, n, {"Any", 24'd0}, 3'd3)) k = K_KW_ANY;
    if (kw_eq(w, n, {"type", 16'd0}, 3'd4)) k = K_KW_TYPE;
    if (kw_eq(w, n, {"if", 32'd0}, 3'd2)) k = K_KW_IF;
    if (kw_eq(w, n, {"else", 16'd0}, 3'd4)) k = K_KW_ELSE;
    if (kw_eq(w, n, {"true", 16'd0}, 3'd4)) k = K_KW_TRUE;
    if (kw_eq(w, n, {"false", 8'd0}, 3'd5)) k = K_KW_FALSE;
    if (kw_eq(w, n, {"fn", 32'd0}, 3'd2)) k = K_KW_FN;
    if (kw_eq(w, n, "return", 3'd6)) k = K_KW_RETURN;
    if (kw_eq(w, n, {"while", 8'd0}, 3'd5)) k = K_KW_WHILE;
    if (kw_eq(w, n, {"for", 24'd0}, 3'd3)) k = K_KW_FOR;
    if (kw_eq(w, n, {"Int", 24'd0}, 3'd3)) k = K_KW_INT;
    if (kw_eq(w, n, {"Float", 8'd0}, 3'd5)) k = K_KW_FLOAT;
    if (kw_eq(w, n, {"Bool", 16'd0}, 3'd4)) k = K_KW_BOOL;
    if (kw_eq(w, n, "String", 3'd6)) k = K_KW_STRING;
    return k;
  endfunction

  function automatic kind_e single_kind(logic [7:0] c);
    kind_e k;
    unique case (c)
      8'h2b: k = K_PLUS;
      8'h2a: k = K_STAR;
      8'h25: k = K_PERCENT;
      8'h2c: k = K_COMMA;
      8'h3b: k = K_SEMI;
      8'h3d: k = K_EQUAL;
      8'h28: k = K_PL;
      8'h29: k = K_PR;
      8'h5b: k = K_SL;
      8'h5d: k = K_SR;
      8'h7b: k = K_CL;
      8'h7d: k = K_CR;
      default: k = K_INVALID;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/source_text_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit
// Streaming lexical scanner: one source byte per word in, tokens out.
// ----------------------------------------------------------------------------
// output: a token is offered in the cycle after the byte that completes it
// throughput: one byte per cycle while the output is not stalled; a byte that emits
//   several tokens stalls input while the three-entry queue drains one a cycle
// reset: scan idle, offsets and length zero, result queue empty
module source_text_tokenizer_unit #(
  parameter int unsigned POSITION_BITS = stt_pkg::PositionBits,
  parameter int unsigned LENGTH_BITS   = stt_pkg::LengthBits
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               char_code_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [5:0]               token_kind_o,
  output logic [POSITION_BITS-1:0] token_start_o,
  output logic [LENGTH_BITS-1:0]   token_length_o,
  output logic                     last_of_run_o
);
  import stt_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LenMax = '1;
  localparam logic [LENGTH_BITS-1:0] Len0 = '0;
  localparam logic [LENGTH_BITS-1:0] Len1 = LENGTH_BITS'(1);
  localparam logic [LENGTH_BITS-1:0] Len2 = (LENGTH_BITS > 1) ? LENGTH_BITS'(2) : LenMax;

  typedef struct packed {
    kind_e                    kind;
    logic [POSITION_BITS-1:0] start;
    logic [LENGTH_BITS-1:0]   len;
    logic                     last;
  } tok_t;

  mode_e                    mode_q, mode_d;
  logic [POSITION_BITS-1:0] offs_q, offs_d, begin_q, begin_d;
  logic [LENGTH_BITS-1:0]   run_q, run_d;
  word_t                    word_q, word_d;

  tok_t       slot_q [3];
  tok_t       slot_d [3];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] rd_q, rd_d;

  tok_t       tok [3];
  logic [1:0] ntok;
  logic       accept, pop;

  function automatic logic [LENGTH_BITS-1:0] sat_inc(logic [LENGTH_BITS-1:0] a,
                                                    logic [LENGTH_BITS-1:0] b);
    logic [LENGTH_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LENGTH_BITS] ? LenMax : s[LENGTH_BITS-1:0];
  endfunction

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  // accept when queue will be empty this cycle
  assign in_stall_o  = !((cnt_q == 2'd0) || (cnt_q == 2'd1 && pop));
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    logic [7:0]               c;
    logic                     redo;
    logic [POSITION_BITS-1:0] pos;
    logic [7:0]               f;
    logic [7:0]               sec;
    kind_e                    two, one;
    logic [2:0]               nlen;
    c = char_code_i;
    pos = offs_q;
    mode_d = mode_q;
    begin_d = begin_q;
    run_d = run_q;
    word_d = word_q;
    ntok = 2'd0;
    redo = 1'b0;
    f = word_q[0];
    sec = 8'h3d;
    two = K_INVALID;
    one = K_INVALID;
    nlen = (run_q > LENGTH_BITS'(WordDepth)) ? 3'd7 : run_q[2:0];
    for (int i = 0; i < 3; i++) tok[i] = '{K_INVALID, pos, Len0, 1'b0};

    unique case (mode_q)
      M_PAIR: begin
        unique case (f)
          8'h2d: begin sec = 8'h3e; two = K_ARROW; one = K_MINUS; end
          8'h2f: begin sec = 8'h2f; two = K_DSLASH; one = K_SLASH; end
          8'h3a: begin two = K_ASSIGN; one = K_COLON; end
          8'h21: begin two = K_BANG_EQ; one = K_BANG; end
          8'h3e: begin two = K_GE; one = K_GT; end
          8'h3c: begin two = K_LE; one = K_LT; end
          8'h26: begin sec = 8'h26; two = K_AND; end
          default: begin sec = 8'h7c; two = K_OR; one = K_PIPE; end
        endcase
        mode_d = M_IDLE;
        if (c == sec) begin
          tok[0] = '{two, begin_q, Len2, 1'b0}; ntok = 2'd1;
        end else begin
          tok[0] = '{one, begin_q, (f == 8'h26) ? Len0 : Len1, 1'b0}; ntok = 2'd1;
          redo = 1'b1;
        end
      end
      M_DOT: begin
        if (c == 8'h2e) begin
          mode_d = M_DOTDOT; run_d = sat_inc(run_q, Len1);
        end else begin
          tok[0] = '{K_DOT, begin_q, Len1, 1'b0}; ntok = 2'd1;
          mode_d = M_IDLE; redo = 1'b1;
        end
      end
      M_DOTDOT: begin
        mode_d = M_IDLE;
        if (c == 8'h2e) begin
          tok[0] = '{K_ELLIPSIS, begin_q, sat_inc(run_q, Len1), 1'b0}; ntok = 2'd1;
        end else begin
          tok[0] = '{K_INVALID, begin_q, Len0, 1'b0}; ntok = 2'd1; redo = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_ident_char(c) || is_digit(c)) begin
          for (int i = 1; i < WordDepth; i++)
            if (run_q == LENGTH_BITS'(i)) word_d[i] = c;
          run_d = sat_inc(run_q, Len1);
        end else begin
          tok[0] = '{ident_kind(word_q, nlen), begin_q, run_q, 1'b0}; ntok = 2'd1;
          mode_d = M_IDLE; redo = 1'b1;
        end
      end
      M_INT: begin
        if (is_digit(c)) run_d = sat_inc(run_q, Len1);
        else if (c == 8'h2e) mode_d = M_INTDOT;
        else begin
          tok[0] = '{K_INT, begin_q, run_q, 1'b0}; ntok = 2'd1;
          mode_d = M_IDLE; redo = 1'b1;
        end
      end
      M_INTDOT: begin
        if (is_digit(c)) begin
          mode_d = M_FLOAT; run_d = sat_inc(run_q, Len2);
        end else begin
          tok[0] = '{K_INT, begin_q, run_q, 1'b0};
          ntok = 2'd1;
          begin_d = pos - POSITION_BITS'(1);
          run_d = Len1;
          if (c == 8'h2e) begin
            mode_d = M_DOTDOT; run_d = sat_inc(Len1, Len1);
          end else begin
            tok[1] = '{K_DOT, pos - POSITION_BITS'(1), Len1, 1'b0}; ntok = 2'd2;
            mode_d = M_IDLE; redo = 1'b1;
          end
        end
      end
      M_FLOAT: begin
        if (is_digit(c)) run_d = sat_inc(run_q, Len1);
        else begin
          tok[0] = '{K_FLOAT, begin_q, run_q, 1'b0}; ntok = 2'd1;
          mode_d = M_IDLE; redo = 1'b1;
        end
      end
      M_STRING: begin
        if (c == 8'h27) begin
          tok[0] = '{K_STRING, begin_q, sat_inc(run_q, Len1), 1'b0}; ntok = 2'd1;
          mode_d = M_IDLE;
        end else if (c == 8'h00) begin
          tok[0] = '{K_STRING, begin_q, run_q, 1'b0}; ntok = 2'd1;
          mode_d = M_IDLE; redo = 1'b1;
        end else run_d = sat_inc(run_q, Len1);
      end
      M_COMMENT: begin
        if (c == 8'h0a || c == 8'h00) begin
          tok[0] = '{K_COMMENT, begin_q, run_q, 1'b0}; ntok = 2'd1;
          mode_d = M_IDLE; redo = 1'b1;
        end else run_d = sat_inc(run_q, Len1);
      end
      default: redo = 1'b1;
    endcase

    if (redo) begin
      mode_d = M_IDLE;
      priority if (c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a) begin
      end else if (c == 8'h00) begin
        tok[ntok] = '{K_EOF, pos, Len1, 1'b0}; ntok = ntok + 2'd1;
      end else if (c == 8'h2d || c == 8'h2f || c == 8'h3a || c == 8'h21 ||
                   c == 8'h3e || c == 8'h3c || c == 8'h26 || c == 8'h7c) begin
        mode_d = M_PAIR; begin_d = pos; run_d = Len1; word_d[0] = c;
      end else if (c == 8'h2e) begin
        mode_d = M_DOT; begin_d = pos; run_d = Len1;
      end else if (c == 8'h23) begin
        mode_d = M_COMMENT; begin_d = pos; run_d = Len1;
      end else if (c == 8'h27) begin
        mode_d = M_STRING; begin_d = pos; run_d = Len1;
      end else if (is_digit(c)) begin
        mode_d = M_INT; begin_d = pos; run_d = Len1;
      end else if (is_ident_char(c)) begin
        mode_d = M_IDENT; begin_d = pos; run_d = Len1; word_d[0] = c;
      end else begin
        tok[ntok] = '{single_kind(c), pos, Len1, 1'b0}; ntok = ntok + 2'd1;
      end
    end
    if (ntok != 2'd0) tok[ntok - 2'd1].last = 1'b1;
    offs_d = (c == 8'h00) ? '0 : pos + POSITION_BITS'(1);
  end

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    for (int i = 0; i < 3; i++) slot_d[i] = slot_q[i];
    if (pop) begin
      cnt_d = cnt_q - 2'd1;
      rd_d  = rd_q + 2'd1;
    end
    if (accept) begin
      for (int i = 0; i < 3; i++) slot_d[i] = tok[i];
      cnt_d = ntok;
      rd_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      offs_q  <= '0;
      begin_q <= '0;
      run_q   <= '0;
      cnt_q   <= 2'd0;
      rd_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
      if (accept) begin
        mode_q  <= mode_d;
        offs_q  <= offs_d;
        begin_q <= begin_d;
        run_q   <= run_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) word_q <= word_d;
    for (int i = 0; i < 3; i++) slot_q[i] <= slot_d[i];
  end

  assign token_kind_o   = slot_q[rd_q].kind;
  assign token_start_o  = slot_q[rd_q].start;
  assign token_length_o = slot_q[rd_q].len;
  assign last_of_run_o  = slot_q[rd_q].last;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3 || rd_q == 2'd0) else $error("queue index out of range");
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cnt_q == 2'd1) |-> last_of_run_o)
    else $error("final token lacks last flag");
  a_mid_nolast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cnt_q > 2'd1) |-> !last_of_run_o)
    else $error("last flag before end of run");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q > 2'd1) |-> in_stall_o) else $error("accept while queue busy");
endmodule

// ===== dv/tb_source_text_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_source_text_tokenizer_unit
// Streams source bytes into the tokenizer and checks every token it emits
// (kind, start offset, length, last flag) against a scanner model kept in the
// bench. Covers operators, literals, keywords, comments, strings, noise
// bytes, back-pressure and several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_source_text_tokenizer_unit;
  import stt_pkg::*;

  localparam int LenMax = 65535;
  localparam longint CycleLimit = 3000000;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] start;
    logic [15:0] len;
    logic        last;
  } token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_code_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [5:0]  token_kind_o;
  logic [31:0] token_start_o;
  logic [15:0] token_length_o;
  logic        last_of_run_o;

  source_text_tokenizer_unit uut (.*);

  // scanner state mirrored by the bench
  mode_e       scan_mode;
  logic [31:0] byte_pos;
  logic [31:0] tok_begin;
  int          tok_len;
  logic [7:0]  word_buf [WordDepth];
  token_t      step_tokens[$];
  token_t      pending_tokens[$];

  int     idle_pct = 0;
  int     stall_pct = 0;
  int     hold_cycles = 0;
  int     errors = 0;
  longint cycles = 0;
  logic [7:0] src_q[$];

  string kw_names [14] = '{"Any", "type", "if", "else", "true", "false", "fn",
                           "return", "while", "for", "Int", "Float", "Bool",
                           "String"};
  string op_names [31] = '{"->", "//", ":=", "!=", ">=", "<=", "&&", "||", "-",
                           "/", ":", "!", ">", "<", "&", "|", "+", "*", "%",
                           ",", ";", "=", "(", ")", "[", "]", "{", "}", ".",
                           "..", "..."};

  initial forever #10 clk_i = ~clk_i;

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic int sat_add(int a, int b);
    return (a + b > LenMax) ? LenMax : a + b;
  endfunction

  function automatic void put_token(kind_e k, logic [31:0] s, int n);
    token_t t;
    if (step_tokens.size() >= 3) return;
    t.kind = k;
    t.start = s;
    t.len = (n > LenMax) ? 16'hffff : n[15:0];
    t.last = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void open_token(mode_e m, logic [31:0] pos);
    scan_mode = m;
    tok_begin = pos;
    tok_len = 1;
  endfunction

  function automatic kind_e word_kind();
    bit hit;
    if (tok_len > WordDepth) return K_IDENT;
    for (int i = 0; i < 14; i++) begin
      hit = (kw_names[i].len() == tok_len);
      for (int j = 0; j < kw_names[i].len() && hit; j++)
        if (kw_names[i].getc(j) != word_buf[j]) hit = 0;
      if (hit) return kind_e'(int'(K_KW_ANY) + i);
    end
    return K_IDENT;
  endfunction

  function automatic kind_e lone_kind(logic [7:0] c);
    case (c)
      "+": return K_PLUS;
      "*": return K_STAR;
      "%": return K_PERCENT;
      ",": return K_COMMA;
      ";": return K_SEMI;
      "=": return K_EQUAL;
      "(": return K_PL;
      ")": return K_PR;
      "[": return K_SL;
      "]": return K_SR;
      "{": return K_CL;
      "}": return K_CR;
      default: return K_INVALID;
    endcase
  endfunction

  function automatic bit pair_byte(logic [7:0] c);
    logic [7:0] f;
    int second;
    kind_e two, one;
    f = word_buf[0];
    second = int'("=");
    two = K_INVALID;
    one = K_INVALID;
    case (f)
      "-": begin second = int'(">"); two = K_ARROW; one = K_MINUS; end
      "/": begin second = int'("/"); two = K_DSLASH; one = K_SLASH; end
      ":": begin two = K_ASSIGN; one = K_COLON; end
      "!": begin two = K_BANG_EQ; one = K_BANG; end
      ">": begin two = K_GE; one = K_GT; end
      "<": begin two = K_LE; one = K_LT; end
      "&": begin second = int'("&"); two = K_AND; end
      "|": begin second = int'("|"); two = K_OR; one = K_PIPE; end
      default: second = 256;
    endcase
    scan_mode = M_IDLE;
    if (int'(c) == second) begin
      put_token(two, tok_begin, 2);
      return 1;
    end
    put_token(one, tok_begin, (f == "&") ? 0 : 1);
    return 0;
  endfunction

  // returns 1 when the byte is consumed by the open token
  function automatic bit continue_token(logic [7:0] c);
    case (scan_mode)
      M_PAIR: return pair_byte(c);
      M_DOT: begin
        if (c == ".") begin
          scan_mode = M_DOTDOT;
          tok_len = sat_add(tok_len, 1);
          return 1;
        end
        put_token(K_DOT, tok_begin, 1);
        scan_mode = M_IDLE;
        return 0;
      end
      M_DOTDOT: begin
        scan_mode = M_IDLE;
        if (c == ".") begin
          put_token(K_ELLIPSIS, tok_begin, sat_add(tok_len, 1));
          return 1;
        end
        put_token(K_INVALID, tok_begin, 0);
        return 0;
      end
      M_IDENT: begin
        if (is_letter(c) || is_num(c)) begin
          if (tok_len < WordDepth) word_buf[tok_len] = c;
          tok_len = sat_add(tok_len, 1);
          return 1;
        end
        put_token(word_kind(), tok_begin, tok_len);
        scan_mode = M_IDLE;
        return 0;
      end
      M_INT: begin
        if (is_num(c)) begin
          tok_len = sat_add(tok_len, 1);
          return 1;
        end
        if (c == ".") begin
          scan_mode = M_INTDOT;
          return 1;
        end
        put_token(K_INT, tok_begin, tok_len);
        scan_mode = M_IDLE;
        return 0;
      end
      M_INTDOT: begin
        scan_mode = M_FLOAT;
        tok_len = sat_add(tok_len, 2);
        return 1;
      end
      M_FLOAT: begin
        if (is_num(c)) begin
          tok_len = sat_add(tok_len, 1);
          return 1;
        end
        put_token(K_FLOAT, tok_begin, tok_len);
        scan_mode = M_IDLE;
        return 0;
      end
      M_STRING: begin
        if (c == "'") begin
          put_token(K_STRING, tok_begin, sat_add(tok_len, 1));
          scan_mode = M_IDLE;
          return 1;
        end
        if (c == 8'h00) begin
          put_token(K_STRING, tok_begin, tok_len);
          scan_mode = M_IDLE;
          return 0;
        end
        tok_len = sat_add(tok_len, 1);
        return 1;
      end
      M_COMMENT: begin
        if (c == 8'h0a || c == 8'h00) begin
          put_token(K_COMMENT, tok_begin, tok_len);
          scan_mode = M_IDLE;
          return 0;
        end
        tok_len = sat_add(tok_len, 1);
        return 1;
      end
      default: begin
        scan_mode = M_IDLE;
        return 0;
      end
    endcase
  endfunction

  function automatic void begin_token(logic [7:0] c, logic [31:0] pos);
    scan_mode = M_IDLE;
    if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a) return;
    if (c == 8'h00) begin
      put_token(K_EOF, pos, 1);
      return;
    end
    case (c)
      "-", "/", ":", "!", ">", "<", "&", "|": begin
        open_token(M_PAIR, pos);
        word_buf[0] = c;
      end
      ".": open_token(M_DOT, pos);
      "#": open_token(M_COMMENT, pos);
      "'": open_token(M_STRING, pos);
      default: begin
        if (is_num(c)) open_token(M_INT, pos);
        else if (is_letter(c)) begin
          open_token(M_IDENT, pos);
          word_buf[0] = c;
        end else put_token(lone_kind(c), pos, 1);
      end
    endcase
  endfunction

  function automatic void predict_byte(logic [7:0] c);
    logic [31:0] pos;
    pos = byte_pos;
    step_tokens.delete();
    // digits and a dot with no digit after: integer ends, dot rescanned
    if (scan_mode == M_INTDOT && !is_num(c)) begin
      put_token(K_INT, tok_begin, tok_len);
      open_token(M_DOT, pos - 32'd1);
    end
    if (!continue_token(c)) begin_token(c, pos);
    byte_pos = (c == 8'h00) ? 32'd0 : pos + 32'd1;
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
    foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
  endfunction

  // ---------------------------------------------------------------- driving
  task automatic send_byte(logic [7:0] c);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    char_code_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    predict_byte(c);
  endtask

  task automatic send_queued();
    foreach (src_q[i]) send_byte(src_q[i]);
    src_q.delete();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) src_q.push_back(s.getc(i));
  endtask

  task automatic wait_drained();
    while (pending_tokens.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------- checking
  always @(posedge clk_i) begin
    token_t want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL source_text_tokenizer_unit");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_tokens.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected token kind %0d start %0d len %0d", token_kind_o,
                   token_start_o, token_length_o);
      end else begin
        want = pending_tokens.pop_front();
        if (token_kind_o != want.kind || token_start_o != want.start ||
            token_length_o != want.len || last_of_run_o != want.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     want.kind, want.start, want.len, want.last, token_kind_o,
                     token_start_o, token_length_o, last_of_run_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic add_random_token();
    int n;
    logic [7:0] c;
    case ($urandom_range(0, 10))
      0: push_text(kw_names[$urandom_range(0, 13)]);
      1: begin
        n = $urandom_range(1, 9);
        src_q.push_back(8'("a" + $urandom_range(0, 25)));
        for (int i = 1; i < n; i++) begin
          case ($urandom_range(0, 3))
            0: src_q.push_back(8'("0" + $urandom_range(0, 9)));
            1: src_q.push_back("_");
            2: src_q.push_back(8'("A" + $urandom_range(0, 25)));
            default: src_q.push_back(8'("a" + $urandom_range(0, 25)));
          endcase
        end
      end
      2: repeat ($urandom_range(1, 5)) src_q.push_back(8'("0" + $urandom_range(0, 9)));
      3: begin
        repeat ($urandom_range(1, 3)) src_q.push_back(8'("0" + $urandom_range(0, 9)));
        src_q.push_back(".");
        repeat ($urandom_range(0, 3)) src_q.push_back(8'("0" + $urandom_range(0, 9)));
      end
      4: begin
        src_q.push_back("'");
        repeat ($urandom_range(0, 6)) begin
          do c = 8'($urandom_range(1, 255)); while (c == "'");
          src_q.push_back(c);
        end
        src_q.push_back("'");
      end
      5: begin
        src_q.push_back("#");
        repeat ($urandom_range(0, 6)) begin
          do c = 8'($urandom_range(1, 255)); while (c == 8'h0a);
          src_q.push_back(c);
        end
        src_q.push_back(8'h0a);
      end
      6, 7: push_text(op_names[$urandom_range(0, 30)]);
      8: src_q.push_back(8'($urandom_range(0, 255)));
      9: case ($urandom_range(0, 3))
        0: src_q.push_back(" ");
        1: src_q.push_back(8'h09);
        2: src_q.push_back(8'h0d);
        default: src_q.push_back(8'h0a);
      endcase
      default: push_text(op_names[$urandom_range(0, 7)]);
    endcase
    if ($urandom_range(0, 1)) src_q.push_back(" ");
  endtask

  task automatic random_source();
    repeat ($urandom_range(2, 10)) add_random_token();
    case ($urandom_range(0, 7))
      0: push_text("'open");
      1: push_text("#open");
      default: ;
    endcase
    src_q.push_back(8'h00);
  endtask

  task automatic test_directed();
    push_text("+-->*///%,:;:= . ... ()[]{}#note");
    src_q.push_back(8'h0a);
    push_text("! != = > >= < <= && || | & x .. y 12 3.5 7.x 8..z @");
    src_q.push_back(8'hff);
    src_q.push_back(8'h00);
    push_text("Any type if else true false fn return while for Int Float Bool ");
    push_text("String Strings _id9 'str' 'open");
    src_q.push_back(8'h00);
    push_text("#tail");
    src_q.push_back(8'h00);
    send_queued();
    wait_drained();
  endtask

  task automatic test_random(int idle, int stall, int n_bytes);
    int sent;
    idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < n_bytes) begin
      random_source();
      sent += src_q.size();
      send_queued();
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    @(negedge clk_i);
    hold_cycles = 300;
    repeat (20) push_text("-+&");
    src_q.push_back(8'h00);
    send_queued();
    wait_drained();
  endtask

  initial begin
    scan_mode = M_IDLE;
    byte_pos = '0;
    tok_begin = '0;
    tok_len = 0;
    foreach (word_buf[i]) word_buf[i] = 8'h00;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(0, 0, 50);
    test_random(69, 0, 50);
    test_random(0, 69, 50);
    test_random(31, 31, 50);
    test_backpressure();
    wait_drained();
    if (errors == 0) $display("PASS source_text_tokenizer_unit");
    else $display("FAIL source_text_tokenizer_unit");
    $finish;
  end

endmodule
